/* rtl/ihex_pkg.sv */
// shared types, constants and helpers for the hex record parser
package ihex_pkg;

  localparam int unsigned IHEX_QUEUE_DEPTH = 4;

  localparam logic [7:0] COLON_CODE = 8'h3a;
  localparam logic [7:0] BYTE_MASK  = 8'hff;

  localparam logic       KIND_CHAR = 1'b0;
  localparam logic       KIND_EOF  = 1'b1;

  localparam logic [1:0] RK_WRITE  = 2'd0;
  localparam logic [1:0] RK_RECORD = 2'd1;
  localparam logic [1:0] RK_EOF    = 2'd2;

  localparam logic [16:0] HIGH_END_MAX = 17'h100fe;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        checksum_error;
    logic [15:0] lowest_start;
    logic [16:0] highest_end;
  } out_req_t;

  typedef struct packed {
    logic       is_eof;
    logic       is_colon;
    logic       is_hex;
    logic [3:0] digit;
  } token_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

/* rtl/ihex_front.sv */
// front end: classifies each incoming character into a token
module ihex_front
  import ihex_pkg::*;
(
  input  in_req_t in_req_i,
  output token_t  token_o
);

  logic [4:0] dec;

  always_comb begin
    dec               = hex_decode(in_req_i.char_code);
    token_o.is_eof    = (in_req_i.kind == KIND_EOF);
    token_o.is_colon  = (in_req_i.char_code == COLON_CODE);
    token_o.is_hex    = dec[4];
    token_o.digit     = dec[3:0];
  end

endmodule

/* rtl/ihex_queue.sv */
// small token queue between front end and back end
module ihex_queue
  import ihex_pkg::*;
#(
  parameter int unsigned Depth = IHEX_QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  token_t  push_tok_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output token_t  pop_tok_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  token_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == DepthCnt);
  assign empty_o   = (count_q == '0);
  assign pop_tok_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

/* rtl/ihex_back.sv */
// back end: record state machine, checksum, marks and output register
module ihex_back
  import ihex_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     tok_valid_i,
  output logic     tok_pop_o,
  input  token_t   tok_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_ADDR = 3'd2,
    PH_TYPE = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  dcount_q, dcount_d;
  logic [15:0] fval_q, fval_d;
  logic        fstop_q, fstop_d;
  logic [7:0]  rec_len_q, rec_len_d;
  logic [7:0]  done_q, done_d;
  logic [16:0] run_addr_q, run_addr_d;
  logic [15:0] base_q, base_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] low_q, low_d;
  logic [16:0] high_q, high_d;
  logic        out_valid_q, out_valid_d;
  out_req_t    out_q, out_d;

  logic        pop;
  logic        emit;
  logic [1:0]  rkind;
  logic [15:0] raddr;
  logic [7:0]  rdata;
  logic        rerr;
  logic [15:0] fv;
  logic        fs;
  logic        field_done;
  logic [7:0]  v8;

  assign pop       = tok_valid_i && (!out_valid_q || out_ready_i);
  assign tok_pop_o = pop;

  always_comb begin
    phase_d    = phase_q;
    dcount_d   = dcount_q;
    fval_d     = fval_q;
    fstop_d    = fstop_q;
    rec_len_d  = rec_len_q;
    done_d     = done_q;
    run_addr_d = run_addr_q;
    base_d     = base_q;
    sum_d      = sum_q;
    low_d      = low_q;
    high_d     = high_q;
    emit       = 1'b0;
    rkind      = RK_WRITE;
    raddr      = '0;
    rdata      = '0;
    rerr       = 1'b0;
    fv         = (dcount_q == '0) ? '0 : fval_q;
    fs         = (dcount_q == '0) ? 1'b0 : fstop_q;
    field_done = 1'b0;
    v8         = '0;

    if (pop) begin
      if (tok_i.is_eof) begin
        phase_d  = PH_HUNT;
        dcount_d = '0;
        emit     = 1'b1;
        rkind    = RK_EOF;
      end else if (phase_q == PH_HUNT) begin
        if (tok_i.is_colon) begin
          phase_d  = PH_LEN;
          dcount_d = '0;
        end
      end else begin
        if (!fs && tok_i.is_hex) begin
          fval_d  = {fv[11:0], tok_i.digit};
          fstop_d = 1'b0;
        end else begin
          fval_d  = fv;
          fstop_d = 1'b1;
        end
        dcount_d   = 3'(dcount_q + 1'b1);
        field_done = (phase_q == PH_ADDR) ? (dcount_d == 3'd4) : (dcount_d == 3'd2);
        v8         = fval_d[7:0];
        if (field_done) begin
          dcount_d = '0;
          case (phase_q)
            PH_LEN: begin
              rec_len_d = v8;
              sum_d     = v8;
              phase_d   = PH_ADDR;
            end
            PH_ADDR: begin
              base_d     = fval_d;
              run_addr_d = {1'b0, fval_d};
              sum_d      = 8'(sum_q + fval_d[15:8] + fval_d[7:0]);
              phase_d    = PH_TYPE;
            end
            PH_TYPE: begin
              sum_d = 8'(sum_q + v8);
              if (v8 != '0) begin
                phase_d = PH_HUNT;
              end else begin
                done_d  = '0;
                phase_d = (rec_len_q != '0) ? PH_DATA : PH_SUM;
              end
            end
            PH_DATA: begin
              sum_d      = 8'(sum_q + v8);
              emit       = 1'b1;
              rkind      = RK_WRITE;
              raddr      = run_addr_q[15:0];
              rdata      = v8;
              run_addr_d = 17'(run_addr_q + 1'b1);
              done_d     = 8'(done_q + 1'b1);
              if (done_d == rec_len_q) begin
                phase_d = PH_SUM;
              end
            end
            default: begin
              sum_d = 8'(sum_q + v8);
              rerr  = (sum_d != '0);
              if (low_q > base_q) begin
                low_d = base_q;
              end
              if (high_q < run_addr_q) begin
                high_d = run_addr_q;
              end
              phase_d = PH_HUNT;
              emit    = 1'b1;
              rkind   = RK_RECORD;
              raddr   = base_q;
            end
          endcase
        end
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      out_d.result_kind    = rkind;
      out_d.write_address  = raddr;
      out_d.write_data     = rdata;
      out_d.checksum_error = rerr;
      out_d.lowest_start   = low_d;
      out_d.highest_end    = high_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      dcount_q    <= '0;
      fval_q      <= '0;
      fstop_q     <= 1'b0;
      rec_len_q   <= '0;
      done_q      <= '0;
      run_addr_q  <= '0;
      base_q      <= '0;
      sum_q       <= '0;
      low_q       <= 16'd1;
      high_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      dcount_q    <= dcount_d;
      fval_q      <= fval_d;
      fstop_q     <= fstop_d;
      rec_len_q   <= rec_len_d;
      done_q      <= done_d;
      run_addr_q  <= run_addr_d;
      base_q      <= base_d;
      sum_q       <= sum_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* rtl/intel_hex_record_parser_unit.sv */
// top level of the hex record parser
//
// input channel: in_valid_i / in_ready_o with request in_req_i, one text
// character or an end-of-file marker per request
// output channel: out_valid_o / out_ready_i with request out_req_o, one data
// byte write, record-finished report or end-of-file summary
// throughput: one input request per cycle while the queue has room, set by
// the back end, which retires one token per cycle while its output is free
// path: an accepted input request is written into the token queue, and its
// result, if any, is then registered in the output register
// characters that produce no result are absorbed without output
// a queue of QueueDepth tokens sits between the classifier and the back end;
// in_ready_o drops only when it is full
// when the receiver stalls, the output register holds its request and the
// back end stops, while the queue keeps taking input until full
// reset clears the queue and output register, puts the parser in colon hunt,
// and sets the lowest start mark to one and the highest end mark to zero
module intel_hex_record_parser_unit
  import ihex_pkg::*;
#(
  parameter int unsigned QueueDepth = IHEX_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  token_t front_tok;
  token_t queue_tok;
  logic   q_full, q_empty, q_pop;
  logic   tok_valid;

  ihex_front u_front (
    .in_req_i (in_req_i),
    .token_o  (front_tok)
  );

  ihex_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_tok_i (front_tok),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_tok_o  (queue_tok)
  );

  assign in_ready_o = !q_full;
  assign tok_valid  = !q_empty;

  ihex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_pop_o   (q_pop),
    .tok_i       (queue_tok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

/* rtl/ihex_checker.sv */
// port-level checks for the hex record parser
module ihex_checker
  import ihex_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_req_t out_req_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("output request changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.result_kind == RK_WRITE ||
                    out_req_o.result_kind == RK_RECORD ||
                    out_req_o.result_kind == RK_EOF)
    else $error("unknown result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.result_kind != RK_RECORD |->
      out_req_o.checksum_error == 1'b0)
    else $error("checksum error outside record report");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.highest_end <= HIGH_END_MAX)
    else $error("highest end out of range");

endmodule

bind intel_hex_record_parser_unit ihex_checker u_ihex_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_o   (out_req_o)
);

/* sim/intel_hex_record_parser_unit_test.sv */
// testbench for the hex record parser: directed text table plus random records
`timescale 1ns / 1ps

module intel_hex_record_parser_unit_test;
  import ihex_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RANDOM_CHARS   = 1900;
  localparam int QUIET_TAIL     = 1700;
  localparam int MID_PAUSE      = 950;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_SUM
  } parse_phase_e;

  typedef struct packed {
    in_req_t  req;
    logic     typed;
    out_req_t res;
  } stim_row_t;

  localparam stim_row_t DIRECTED_TEXT [26] = '{
    '{'{KIND_EOF, 8'h00}, 1'b1, '{RK_EOF, 16'h0000, 8'h00, 1'b0, 16'h0001, 17'h00000}},
    '{'{KIND_CHAR, COLON_CODE}, 1'b0, '0},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "1"}, 1'b0, '0},
    '{'{KIND_CHAR, "F"}, 1'b0, '0},
    '{'{KIND_CHAR, "F"}, 1'b0, '0},
    '{'{KIND_CHAR, "F"}, 1'b0, '0},
    '{'{KIND_CHAR, "F"}, 1'b0, '0},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "f"}, 1'b0, '0},
    '{'{KIND_CHAR, "f"}, 1'b1, '{RK_WRITE, 16'hffff, 8'hff, 1'b0, 16'h0001, 17'h00000}},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "2"}, 1'b1, '{RK_RECORD, 16'hffff, 8'h00, 1'b0, 16'h0001, 17'h10000}},
    '{'{KIND_CHAR, COLON_CODE}, 1'b0, '0},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "g"}, 1'b0, '0},
    '{'{KIND_CHAR, COLON_CODE}, 1'b0, '0},
    '{'{KIND_CHAR, "2"}, 1'b0, '0},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "0"}, 1'b0, '0},
    '{'{KIND_CHAR, "1"}, 1'b0, '0},
    '{'{KIND_CHAR, "Z"}, 1'b1, '{RK_RECORD, 16'h0000, 8'h00, 1'b1, 16'h0000, 17'h10000}},
    '{'{KIND_EOF, 8'h5a}, 1'b1, '{RK_EOF, 16'h0000, 8'h00, 1'b0, 16'h0000, 17'h10000}}
  };

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_req_t out_req_o;

  intel_hex_record_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  parse_phase_e ph         = PH_HUNT;
  logic [2:0]   dcount     = '0;
  logic [15:0]  fval       = '0;
  logic         fstop      = 1'b0;
  logic [7:0]   rec_len    = '0;
  logic [7:0]   bytes_done = '0;
  logic [16:0]  run_addr   = '0;
  logic [15:0]  rec_base   = '0;
  logic [7:0]   bsum       = '0;
  logic [15:0]  low_mark   = 16'h0001;
  logic [16:0]  high_mark  = '0;

  out_req_t pending_results[$];
  in_req_t  hex_text[$];
  int       chars_sent = 0;
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  int       gap_pct = 20;
  int       stall_pct = 20;
  out_req_t want_r;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic out_req_t make_result(logic [1:0] k, logic [15:0] a, logic [7:0] d,
                                           logic e);
    out_req_t o;
    o.result_kind    = k;
    o.write_address  = a;
    o.write_data     = d;
    o.checksum_error = e;
    o.lowest_start   = low_mark;
    o.highest_end    = high_mark;
    return o;
  endfunction

  function automatic bit parse_char(input in_req_t r, output out_req_t res);
    int          dig;
    int          need;
    logic [15:0] v;
    res = '0;
    if (r.kind == KIND_EOF) begin
      ph = PH_HUNT;
      dcount = '0;
      res = make_result(RK_EOF, '0, '0, 1'b0);
      return 1'b1;
    end
    if (ph == PH_HUNT) begin
      if (r.char_code == COLON_CODE) begin
        ph = PH_LEN;
        dcount = '0;
      end
      return 1'b0;
    end
    if (dcount == 0) begin
      fval = '0;
      fstop = 1'b0;
    end
    dig = hex_digit(r.char_code);
    if (!fstop && dig >= 0) begin
      fval = {fval[11:0], 4'(dig)};
    end else begin
      fstop = 1'b1;
    end
    dcount++;
    need = (ph == PH_ADDR) ? 4 : 2;
    if (int'(dcount) < need) return 1'b0;
    dcount = '0;
    v = fval;
    case (ph)
      PH_LEN: begin
        rec_len = v[7:0];
        bsum = v[7:0];
        ph = PH_ADDR;
      end
      PH_ADDR: begin
        rec_base = v;
        run_addr = {1'b0, v};
        bsum = bsum + v[15:8] + v[7:0];
        ph = PH_TYPE;
      end
      PH_TYPE: begin
        bsum = bsum + v[7:0];
        if (v != 0) begin
          ph = PH_HUNT;
        end else begin
          bytes_done = '0;
          ph = (rec_len != 0) ? PH_DATA : PH_SUM;
        end
      end
      PH_DATA: begin
        bsum = bsum + v[7:0];
        res = make_result(RK_WRITE, run_addr[15:0], v[7:0], 1'b0);
        run_addr = run_addr + 17'd1;
        bytes_done = bytes_done + 8'd1;
        if (bytes_done == rec_len) ph = PH_SUM;
        return 1'b1;
      end
      default: begin
        bsum = bsum + v[7:0];
        if (low_mark > rec_base) low_mark = rec_base;
        if (high_mark < run_addr) high_mark = run_addr;
        ph = PH_HUNT;
        res = make_result(RK_RECORD, rec_base, 8'h00, bsum != 0);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_ascii(logic [3:0] n);
    if (n < 4'd10) return 8'(n) + 8'h30;
    return 8'(n - 4'd10) + ($urandom_range(1) ? 8'h41 : 8'h61);
  endfunction

  task automatic queue_hex(logic [15:0] val, int digits);
    logic [15:0] sh;
    for (int i = digits - 1; i >= 0; i--) begin
      sh = val >> (4 * i);
      hex_text.push_back('{KIND_CHAR, hex_ascii(sh[3:0])});
    end
  endtask

  task automatic queue_record(logic [7:0] rtype, bit bad_sum);
    int          r;
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [7:0]  d;
    logic [15:0] addr;
    r = $urandom_range(99);
    if (rtype != 8'h00) len = 8'($urandom_range(4));
    else if (r < 3) len = 8'($urandom_range(255, 200));
    else if (r < 13) len = 8'($urandom_range(32, 9));
    else len = 8'($urandom_range(8));
    addr = ($urandom_range(4) == 0) ? 16'hfff0 + 16'($urandom_range(15))
                                    : 16'($urandom_range(16'hffff));
    hex_text.push_back('{KIND_CHAR, COLON_CODE});
    queue_hex(16'(len), 2);
    queue_hex(addr, 4);
    queue_hex(16'(rtype), 2);
    sum = len + addr[15:8] + addr[7:0] + rtype;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      queue_hex(16'(d), 2);
      sum = sum + d;
    end
    sum = ~sum + 8'd1;
    if (bad_sum) sum = sum + 8'($urandom_range(255, 1));
    queue_hex(16'(sum), 2);
  endtask

  task automatic drive_request(in_req_t r);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic send_text(bit counted);
    in_req_t  r;
    out_req_t res;
    while (hex_text.size() != 0) begin
      r = hex_text.pop_front();
      drive_request(r);
      if (parse_char(r, res)) pending_results.push_back(res);
      if (counted) chars_sent++;
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // receiver side back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if ($urandom_range(99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(9, 1)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_req_o);
        mismatch_count++;
      end else begin
        want_r = pending_results.pop_front();
        check_field("result_kind", 17'(want_r.result_kind), 17'(out_req_o.result_kind));
        check_field("write_address", 17'(want_r.write_address),
                    17'(out_req_o.write_address));
        check_field("write_data", 17'(want_r.write_data), 17'(out_req_o.write_data));
        check_field("checksum_error", 17'(want_r.checksum_error),
                    17'(out_req_o.checksum_error));
        check_field("lowest_start", 17'(want_r.lowest_start), 17'(out_req_o.lowest_start));
        check_field("highest_end", want_r.highest_end, out_req_o.highest_end);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    out_req_t res;
    in_req_t  tmp;
    bit       got;
    bit       paused;
    int       pick;
    int       pos;
    int       next_mood;
    paused = 1'b0;
    next_mood = 150;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_TEXT[i]) begin
      drive_request(DIRECTED_TEXT[i].req);
      got = parse_char(DIRECTED_TEXT[i].req, res);
      if (DIRECTED_TEXT[i].typed) pending_results.push_back(DIRECTED_TEXT[i].res);
      else if (got) pending_results.push_back(res);
    end
    drain_results();

    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent >= QUIET_TAIL) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (chars_sent >= next_mood) begin
        next_mood += 150;
        case ($urandom_range(2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      if (!paused && chars_sent >= MID_PAUSE) begin
        paused = 1'b1;
        drain_results();
      end

      pick = $urandom_range(99);
      if (pick < 60) begin
        queue_record(8'h00, $urandom_range(99) < 15);
      end else if (pick < 72) begin
        queue_record(8'($urandom_range(255, 1)), 1'b0);
      end else if (pick < 84) begin
        // one character of a good record replaced, sometimes by a colon
        queue_record(8'h00, 1'b0);
        pos = $urandom_range(hex_text.size() - 1);
        tmp = hex_text[pos];
        tmp.char_code = ($urandom_range(3) == 0) ? COLON_CODE : 8'($urandom);
        hex_text[pos] = tmp;
      end else if (pick < 94) begin
        // end of file in the middle of a record
        queue_record(8'h00, 1'b0);
        pos = $urandom_range(hex_text.size() - 1, 1);
        hex_text = hex_text[0:pos-1];
        hex_text.push_back('{KIND_EOF, 8'($urandom)});
      end else begin
        hex_text.push_back('{KIND_EOF, 8'($urandom)});
      end
      send_text(1'b1);

      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(3, 1)) hex_text.push_back('{KIND_CHAR, 8'($urandom)});
        send_text(1'b0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
